FILE: rtl/core/ddpq_pkg.sv
// ddpq_pkg: shared constants, types and codes of the deadline-drop packet queue
// no dependencies; used by the channel interfaces, the core and its checker

package ddpq_pkg;

	localparam int QUEUE_DEPTH = 1024;
	localparam int TIME_WIDTH  = 32;

	localparam int PTR_W      = $clog2(QUEUE_DEPTH);
	localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int ENTRY_W    = TIME_WIDTH + 1;
	localparam int DEADLINE_W = 24;
	localparam int SERVICE_W  = 16;
	localparam int DELAY_W    = 25;
	localparam int LEN_W      = 11;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 24;
	localparam int CMP_W      = (TIME_WIDTH > DEADLINE_W) ? TIME_WIDTH : DEADLINE_W;
	localparam int SUM_W      = ((TIME_WIDTH > SERVICE_W) ? TIME_WIDTH : SERVICE_W) + 1;

	localparam logic [DEADLINE_W-1:0] DATA_DEADLINE_RST  = 24'd11520;
	localparam logic [DEADLINE_W-1:0] VIDEO_DEADLINE_RST = 24'd384;
	localparam logic [SERVICE_W-1:0]  DATA_SERVICE_RST   = 16'd6;
	localparam logic [SERVICE_W-1:0]  VIDEO_SERVICE_RST  = 16'd3;

	localparam logic [CFG_IDX_W-1:0] REG_DATA_DEADLINE  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VIDEO_DEADLINE = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DATA_SERVICE   = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VIDEO_SERVICE  = 8'd3;

	localparam logic ACT_TICK   = 1'b0;
	localparam logic ACT_ARRIVE = 1'b1;
	localparam logic CLS_DATA   = 1'b0;
	localparam logic CLS_VIDEO  = 1'b1;

	typedef struct packed {
		logic                  cls;
		logic [TIME_WIDTH-1:0] stamp;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_EMIT
	} ddpq_state_t;

endpackage

FILE: rtl/core/ddpq_if.sv
// ddpq_if: valid/ready channel interfaces of the packet queue (command, result, config)
// depends on ddpq_pkg for payload widths

interface ddpq_cmd_if;
	logic valid;
	logic ready;
	logic action;
	logic packet_class;
	modport source (output valid, action, packet_class, input ready);
	modport sink   (input valid, action, packet_class, output ready);
endinterface

interface ddpq_res_if;
	logic                         valid;
	logic                         ready;
	logic                         accepted;
	logic                         sent;
	logic                         sent_class;
	logic [ddpq_pkg::DELAY_W-1:0] sent_delay;
	logic [ddpq_pkg::LEN_W-1:0]   data_dropped;
	logic [ddpq_pkg::LEN_W-1:0]   video_dropped;
	logic [ddpq_pkg::LEN_W-1:0]   queue_length;
	modport source (output valid, accepted, sent, sent_class, sent_delay, data_dropped,
		video_dropped, queue_length, input ready);
	modport sink   (input valid, accepted, sent, sent_class, sent_delay, data_dropped,
		video_dropped, queue_length, output ready);
endinterface

interface ddpq_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [ddpq_pkg::CFG_IDX_W-1:0]  index;
	logic [ddpq_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/ddpq_ram.sv
// ddpq_ram: generic single-write, single-read synchronous ram with registered read
// no dependencies

module ddpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/core/deadline_drop_packet_queue.sv
// deadline_drop_packet_queue: two-class packet fifo with busy timer and deadline drop
// depends on ddpq_pkg, ddpq_if (channel interfaces) and ddpq_ram (entry store)

// An arrival item goes from the idle state to the emit state. A tick item does the
// same, but when the link is idle and the queue is not empty it first pops head
// entries (dropped or sent) in the eval state: the entry store has one read port and
// the head is evaluated one entry per cycle. The next item is accepted while the
// previous result still waits in the output register; the block only stalls when a
// second result is ready and the first has not been taken. No clearing pass at reset.

module deadline_drop_packet_queue (
	input  logic       clk,
	input  logic       arst_n,
	ddpq_cfg_if.sink   cfg,
	ddpq_cmd_if.sink   cmd,
	ddpq_res_if.source res
);

	ddpq_pkg::ddpq_state_t state_q, state_d;

	logic [ddpq_pkg::DEADLINE_W-1:0] ddl_data_q, ddl_video_q;
	logic [ddpq_pkg::SERVICE_W-1:0]  svc_data_q, svc_video_q;
	logic [ddpq_pkg::DEADLINE_W-1:0] thr_data_q, thr_video_q;
	logic                            all_data_q, all_video_q;

	logic [ddpq_pkg::PTR_W-1:0]      head_q, tail_q, head_next, tail_next;
	logic [ddpq_pkg::CNT_W-1:0]      count_q;
	logic [ddpq_pkg::TIME_WIDTH-1:0] tick_q;
	logic [ddpq_pkg::SERVICE_W-1:0]  busy_q, busy_new;
	logic                            first_done_q;

	logic                            acc_q, sent_q, sent_cls_q;
	logic [ddpq_pkg::TIME_WIDTH-1:0] age_q;
	logic [ddpq_pkg::CNT_W-1:0]      ddrop_q, vdrop_q;

	logic                            res_valid_q;
	logic                            out_acc_q, out_sent_q, out_cls_q;
	logic [ddpq_pkg::DELAY_W-1:0]    out_delay_q;
	logic [ddpq_pkg::LEN_W-1:0]      out_ddrop_q, out_vdrop_q, out_len_q;

	logic                            accept, is_arrive, full;
	logic                            ram_we, ram_re, load_res;
	logic [ddpq_pkg::PTR_W-1:0]      ram_raddr;
	logic [ddpq_pkg::ENTRY_W-1:0]    ram_rdata;
	ddpq_pkg::entry_t                wr_entry, rd_entry;

	logic [ddpq_pkg::TIME_WIDTH-1:0] age;
	logic                            ev_video, ev_all, ev_drop, more_left;
	logic [ddpq_pkg::DEADLINE_W-1:0] ev_thr;
	logic [ddpq_pkg::SERVICE_W-1:0]  ev_svc, emit_svc;
	logic [ddpq_pkg::SUM_W-1:0]      emit_sum;

	assign cfg.ready = 1'b1;
	assign accept    = cmd.valid && cmd.ready;
	assign is_arrive = cmd.action == ddpq_pkg::ACT_ARRIVE;
	assign full      = count_q == ddpq_pkg::CNT_W'(ddpq_pkg::QUEUE_DEPTH);

	assign head_next = (head_q == ddpq_pkg::PTR_W'(ddpq_pkg::QUEUE_DEPTH - 1)) ? '0
		: head_q + 1'b1;
	assign tail_next = (tail_q == ddpq_pkg::PTR_W'(ddpq_pkg::QUEUE_DEPTH - 1)) ? '0
		: tail_q + 1'b1;

	always_comb begin
		busy_new = busy_q;
		if (first_done_q && busy_q != '0) begin
			busy_new = busy_q - 1'b1;
		end
	end

	assign wr_entry.cls   = cmd.packet_class;
	assign wr_entry.stamp = tick_q;
	assign rd_entry       = ddpq_pkg::entry_t'(ram_rdata);

	// head evaluation: age + service >= deadline  <=>  age >= deadline - service
	assign age       = tick_q - rd_entry.stamp;
	assign ev_video  = rd_entry.cls == ddpq_pkg::CLS_VIDEO;
	assign ev_thr    = ev_video ? thr_video_q : thr_data_q;
	assign ev_all    = ev_video ? all_video_q : all_data_q;
	assign ev_svc    = ev_video ? svc_video_q : svc_data_q;
	assign ev_drop   = ev_all || (ddpq_pkg::CMP_W'(age) >= ddpq_pkg::CMP_W'(ev_thr));
	assign more_left = count_q != ddpq_pkg::CNT_W'(1);

	assign emit_svc = (sent_cls_q == ddpq_pkg::CLS_VIDEO) ? svc_video_q : svc_data_q;
	assign emit_sum = ddpq_pkg::SUM_W'(age_q) + ddpq_pkg::SUM_W'(emit_svc);

	ddpq_ram #(
		.WIDTH(ddpq_pkg::ENTRY_W),
		.DEPTH(ddpq_pkg::QUEUE_DEPTH)
	) u_entry_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(tail_q),
		.wdata(wr_entry),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ddpq_pkg::ST_IDLE: begin
				if (accept) begin
					if (is_arrive) begin
						state_d = ddpq_pkg::ST_EMIT;
					end else if (busy_new == '0 && count_q != '0) begin
						state_d = ddpq_pkg::ST_EVAL;
					end else begin
						state_d = ddpq_pkg::ST_EMIT;
					end
				end
			end
			ddpq_pkg::ST_EVAL: begin
				if (!(ev_drop && more_left)) begin
					state_d = ddpq_pkg::ST_EMIT;
				end
			end
			ddpq_pkg::ST_EMIT: begin
				if (load_res) begin
					state_d = ddpq_pkg::ST_IDLE;
				end
			end
			default: state_d = ddpq_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.ready = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = head_q;
		load_res  = 1'b0;
		case (state_q)
			ddpq_pkg::ST_IDLE: begin
				cmd.ready = 1'b1;
				ram_we    = cmd.valid && is_arrive && !full;
				ram_re    = cmd.valid && !is_arrive;
			end
			ddpq_pkg::ST_EVAL: begin
				ram_re    = ev_drop && more_left;
				ram_raddr = head_next;
			end
			ddpq_pkg::ST_EMIT: begin
				load_res = !res_valid_q || res.ready;
			end
			default: begin
				cmd.ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ddl_data_q  <= ddpq_pkg::DATA_DEADLINE_RST;
			ddl_video_q <= ddpq_pkg::VIDEO_DEADLINE_RST;
			svc_data_q  <= ddpq_pkg::DATA_SERVICE_RST;
			svc_video_q <= ddpq_pkg::VIDEO_SERVICE_RST;
			thr_data_q  <= ddpq_pkg::DATA_DEADLINE_RST
				- ddpq_pkg::DEADLINE_W'(ddpq_pkg::DATA_SERVICE_RST);
			thr_video_q <= ddpq_pkg::VIDEO_DEADLINE_RST
				- ddpq_pkg::DEADLINE_W'(ddpq_pkg::VIDEO_SERVICE_RST);
			all_data_q  <= 1'b0;
			all_video_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					ddpq_pkg::REG_DATA_DEADLINE:  ddl_data_q  <= cfg.data;
					ddpq_pkg::REG_VIDEO_DEADLINE: ddl_video_q <= cfg.data;
					ddpq_pkg::REG_DATA_SERVICE:
						svc_data_q  <= cfg.data[ddpq_pkg::SERVICE_W-1:0];
					ddpq_pkg::REG_VIDEO_SERVICE:
						svc_video_q <= cfg.data[ddpq_pkg::SERVICE_W-1:0];
					default: ;
				endcase
			end
			// drop thresholds are registered from the registers, so they follow them in the next cycle
			thr_data_q  <= ddl_data_q - ddpq_pkg::DEADLINE_W'(svc_data_q);
			thr_video_q <= ddl_video_q - ddpq_pkg::DEADLINE_W'(svc_video_q);
			all_data_q  <= ddl_data_q <= ddpq_pkg::DEADLINE_W'(svc_data_q);
			all_video_q <= ddl_video_q <= ddpq_pkg::DEADLINE_W'(svc_video_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ddpq_pkg::ST_IDLE;
			head_q       <= '0;
			tail_q       <= '0;
			count_q      <= '0;
			tick_q       <= '0;
			busy_q       <= '0;
			first_done_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ddpq_pkg::ST_IDLE && accept) begin
				if (is_arrive) begin
					if (!full) begin
						tail_q  <= tail_next;
						count_q <= count_q + 1'b1;
					end
				end else begin
					busy_q       <= busy_new;
					first_done_q <= 1'b1;
					if (first_done_q) begin
						tick_q <= tick_q + 1'b1;
					end
				end
			end
			if (state_q == ddpq_pkg::ST_EVAL) begin
				head_q  <= head_next;
				count_q <= count_q - 1'b1;
				if (!ev_drop) begin
					busy_q <= ev_svc;
				end
			end
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ddpq_pkg::ST_IDLE && accept) begin
			acc_q   <= is_arrive && !full;
			sent_q  <= 1'b0;
			ddrop_q <= '0;
			vdrop_q <= '0;
		end
		if (state_q == ddpq_pkg::ST_EVAL) begin
			if (ev_drop) begin
				if (ev_video) begin
					vdrop_q <= vdrop_q + 1'b1;
				end else begin
					ddrop_q <= ddrop_q + 1'b1;
				end
			end else begin
				sent_q     <= 1'b1;
				sent_cls_q <= rd_entry.cls;
				age_q      <= age;
			end
		end
		if (load_res) begin
			out_acc_q   <= acc_q;
			out_sent_q  <= sent_q;
			out_cls_q   <= sent_q && sent_cls_q;
			out_delay_q <= sent_q ? ddpq_pkg::DELAY_W'(emit_sum) : '0;
			out_ddrop_q <= ddpq_pkg::LEN_W'(ddrop_q);
			out_vdrop_q <= ddpq_pkg::LEN_W'(vdrop_q);
			out_len_q   <= ddpq_pkg::LEN_W'(count_q);
		end
	end

	assign res.valid         = res_valid_q;
	assign res.accepted      = out_acc_q;
	assign res.sent          = out_sent_q;
	assign res.sent_class    = out_cls_q;
	assign res.sent_delay    = out_delay_q;
	assign res.data_dropped  = out_ddrop_q;
	assign res.video_dropped = out_vdrop_q;
	assign res.queue_length  = out_len_q;

endmodule

FILE: rtl/core/ddpq_checker.sv
// ddpq_checker: port-level assertions on the packet queue result channel
// depends on ddpq_pkg; bound to deadline_drop_packet_queue at the end of this file

module ddpq_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         res_valid,
	input logic                         res_ready,
	input logic                         res_accepted,
	input logic                         res_sent,
	input logic                         res_sent_class,
	input logic [ddpq_pkg::DELAY_W-1:0] res_sent_delay,
	input logic [ddpq_pkg::LEN_W-1:0]   res_data_dropped,
	input logic [ddpq_pkg::LEN_W-1:0]   res_video_dropped,
	input logic [ddpq_pkg::LEN_W-1:0]   res_queue_length
);

	// stalled result keeps valid
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result valid dropped while stalled");

	// an accepted arrival never reports service activity and leaves a nonempty queue
	a_arrival_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_accepted |-> !res_sent && res_data_dropped == '0
			&& res_video_dropped == '0 && res_queue_length != '0)
		else $error("accepted arrival carries tick fields");

	// no send means no send class or delay
	a_unsent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_sent |-> !res_sent_class && res_sent_delay == '0)
		else $error("send fields set without a send");

	// total drops in one tick plus the remaining queue length cannot exceed the queue capacity
	a_drop_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ({1'b0, res_data_dropped} + {1'b0, res_video_dropped})
			+ {1'b0, res_queue_length} <= (ddpq_pkg::LEN_W + 1)'(ddpq_pkg::QUEUE_DEPTH))
		else $error("drops plus length exceed queue depth");

endmodule

bind deadline_drop_packet_queue ddpq_checker u_ddpq_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_accepted     (res.accepted),
	.res_sent         (res.sent),
	.res_sent_class   (res.sent_class),
	.res_sent_delay   (res.sent_delay),
	.res_data_dropped (res.data_dropped),
	.res_video_dropped(res.video_dropped),
	.res_queue_length (res.queue_length)
);

FILE: test/ddpq_outcome_checker.sv
// ddpq_outcome_checker: watches the config, command and result channels of the packet queue,
// keeps its own copy of the queue, predicts every result and compares it field by field
// depends on ddpq_pkg and the channel interfaces in ddpq_if

module ddpq_outcome_checker (
	input  logic clk,
	input  logic arst_n,
	ddpq_cfg_if  cfg,
	ddpq_cmd_if  cmd,
	ddpq_res_if  res,
	output int   errors,
	output int   pending
);
	import ddpq_pkg::*;

	typedef struct packed {
		logic               accepted;
		logic               sent;
		logic               sent_class;
		logic [DELAY_W-1:0] sent_delay;
		logic [LEN_W-1:0]   data_dropped;
		logic [LEN_W-1:0]   video_dropped;
		logic [LEN_W-1:0]   queue_length;
	} outcome_t;

	logic [DEADLINE_W-1:0] data_deadline;
	logic [DEADLINE_W-1:0] video_deadline;
	logic [SERVICE_W-1:0]  data_service;
	logic [SERVICE_W-1:0]  video_service;

	entry_t                slots [QUEUE_DEPTH];
	logic [PTR_W-1:0]      head;
	logic [PTR_W-1:0]      tail;
	int unsigned           held;
	logic [TIME_WIDTH-1:0] now;
	logic [SERVICE_W-1:0]  busy;
	logic                  started;
	outcome_t              due [$];

	function automatic string show(outcome_t o);
		return $sformatf("acc=%0b sent=%0b cls=%0b delay=%0d drop=%0d/%0d len=%0d",
			o.accepted, o.sent, o.sent_class, o.sent_delay, o.data_dropped,
			o.video_dropped, o.queue_length);
	endfunction

	// one item against the queue copy: enqueue, or advance time and serve the head
	function automatic outcome_t serve(logic act, logic pcls);
		outcome_t              o;
		entry_t                e;
		logic [TIME_WIDTH-1:0] age;
		logic [SERVICE_W-1:0]  svc;
		logic [DEADLINE_W-1:0] ddl;
		logic [SUM_W-1:0]      total;
		o = '0;
		if (act == ACT_ARRIVE) begin
			if (held < QUEUE_DEPTH) begin
				slots[tail] = '{cls: pcls, stamp: now};
				tail = tail + 1'b1;
				held++;
				o.accepted = 1'b1;
			end
			o.queue_length = LEN_W'(held);
			return o;
		end
		if (started) begin
			if (busy != '0)
				busy = busy - 1'b1;
			now = now + 1'b1;
		end else
			started = 1'b1;
		if (busy == '0) begin
			while (held > 0) begin
				e = slots[head];
				age = now - e.stamp;
				svc = (e.cls == CLS_VIDEO) ? video_service : data_service;
				ddl = (e.cls == CLS_VIDEO) ? video_deadline : data_deadline;
				total = SUM_W'(age) + SUM_W'(svc);
				head = head + 1'b1;
				held--;
				if (total >= SUM_W'(ddl)) begin
					if (e.cls == CLS_VIDEO)
						o.video_dropped = o.video_dropped + 1'b1;
					else
						o.data_dropped = o.data_dropped + 1'b1;
				end else begin
					o.sent = 1'b1;
					o.sent_class = e.cls;
					o.sent_delay = total[DELAY_W-1:0];
					busy = svc;
					break;
				end
			end
		end
		o.queue_length = LEN_W'(held);
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t got;
		outcome_t want;
		if (!arst_n) begin
			data_deadline  = DATA_DEADLINE_RST;
			video_deadline = VIDEO_DEADLINE_RST;
			data_service   = DATA_SERVICE_RST;
			video_service  = VIDEO_SERVICE_RST;
			head = '0;
			tail = '0;
			held = 0;
			now = '0;
			busy = '0;
			started = 1'b0;
			due.delete();
			errors = 0;
			pending <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_DATA_DEADLINE:  data_deadline  = cfg.data[DEADLINE_W-1:0];
					REG_VIDEO_DEADLINE: video_deadline = cfg.data[DEADLINE_W-1:0];
					REG_DATA_SERVICE:   data_service   = cfg.data[SERVICE_W-1:0];
					REG_VIDEO_SERVICE:  video_service  = cfg.data[SERVICE_W-1:0];
					default: ;
				endcase
			end
			if (cmd.valid && cmd.ready)
				due.push_back(serve(cmd.action, cmd.packet_class));
			if (res.valid && res.ready) begin
				got = '{accepted: res.accepted, sent: res.sent, sent_class: res.sent_class,
					sent_delay: res.sent_delay, data_dropped: res.data_dropped,
					video_dropped: res.video_dropped, queue_length: res.queue_length};
				if (due.size() == 0) begin
					if (errors < 10)
						$display("%0t: result with none expected: %s", $time, show(got));
					errors++;
				end else begin
					want = due.pop_front();
					if (got !== want) begin
						if (errors < 10)
							$display("%0t: mismatch\n  expected %s\n  actual   %s",
								$time, show(want), show(got));
						errors++;
					end
				end
			end
			pending <= due.size();
		end
	end

endmodule

FILE: test/deadline_drop_packet_queue_tb.sv
// deadline_drop_packet_queue_tb: drives ticks, arrivals and register writes into the queue
// with random idling on both sides; ddpq_outcome_checker predicts and compares
// depends on ddpq_pkg, ddpq_if, deadline_drop_packet_queue and ddpq_outcome_checker

module deadline_drop_packet_queue_tb;
	import ddpq_pkg::*;

	localparam int HOLD_CYCLES  = 300;
	localparam int QUIET_CYCLES = 16;

	logic clk = 1'b0;
	logic arst_n;
	logic hold_req;
	int   send_idle;
	int   recv_idle;
	int   err_count;
	int   outstanding;

	ddpq_cfg_if cfg_ch ();
	ddpq_cmd_if cmd_ch ();
	ddpq_res_if res_ch ();

	deadline_drop_packet_queue u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	ddpq_outcome_checker u_chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_ch),
		.cmd     (cmd_ch),
		.res     (res_ch),
		.errors  (err_count),
		.pending (outstanding)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("deadline_drop_packet_queue_tb: errors");
		$finish;
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin
		logic hold_done;
		hold_done = 1'b0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else
				res_ch.ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	task automatic offer_item(input logic act, input logic pcls);
		while ($urandom_range(99) < send_idle) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.action <= act;
		cmd_ch.packet_class <= pcls;
		do @(posedge clk); while (!cmd_ch.ready);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	task automatic load_regs(input logic [DEADLINE_W-1:0] dd, input logic [DEADLINE_W-1:0] vd,
		input logic [SERVICE_W-1:0] ds, input logic [SERVICE_W-1:0] vs);
		write_reg(REG_DATA_DEADLINE, dd);
		write_reg(REG_VIDEO_DEADLINE, vd);
		write_reg(REG_DATA_SERVICE, CFG_DATA_W'(ds));
		write_reg(REG_VIDEO_SERVICE, CFG_DATA_W'(vs));
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic wait_quiet();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	initial begin
		int          ph;
		int          i;
		int unsigned arr_pct;
		arst_n <= 1'b0;
		hold_req <= 1'b0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.action <= ACT_TICK;
		cmd_ch.packet_class <= CLS_DATA;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_DATA_DEADLINE;
		cfg_ch.data <= '0;
		send_idle = 30;
		recv_idle = 51;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: first tick on an empty queue, then sends paced by the busy timer
		offer_item(ACT_TICK, CLS_VIDEO);
		offer_item(ACT_ARRIVE, CLS_DATA);
		offer_item(ACT_ARRIVE, CLS_VIDEO);
		offer_item(ACT_ARRIVE, CLS_VIDEO);
		repeat (7) offer_item(ACT_TICK, CLS_DATA);
		wait_quiet();

		// lowest settings: every queued item is due to expire, but the ticks here only count down the busy timer
		load_regs(1, 1, 1, 1);
		offer_item(ACT_ARRIVE, CLS_DATA);
		offer_item(ACT_ARRIVE, CLS_VIDEO);
		offer_item(ACT_ARRIVE, CLS_VIDEO);
		offer_item(ACT_ARRIVE, CLS_DATA);
		offer_item(ACT_TICK, CLS_VIDEO);
		offer_item(ACT_TICK, CLS_DATA);
		wait_quiet();

		for (ph = 0; ph < 6; ph++) begin
			if (ph < 2) begin
				send_idle = 30;
				recv_idle = 51;
			end else if (ph < 4) begin
				send_idle = 51;
				recv_idle = 30;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			if (ph == 2)
				load_regs(DEADLINE_W'($urandom_range(24'hFFFFFF, 1)),
					DEADLINE_W'($urandom_range(24'hFFFFFF, 1)),
					SERVICE_W'($urandom_range(6, 1)), SERVICE_W'($urandom_range(4, 1)));
			else if (ph == 3)
				load_regs(DEADLINE_W'($urandom_range(64, 1)), DEADLINE_W'($urandom_range(64, 1)),
					SERVICE_W'($urandom_range(16'hFFFF, 1)),
					SERVICE_W'($urandom_range(16'hFFFF, 1)));
			else
				load_regs(DEADLINE_W'($urandom_range(90, 2)), DEADLINE_W'($urandom_range(40, 2)),
					SERVICE_W'($urandom_range(6, 1)), SERVICE_W'($urandom_range(4, 1)));
			arr_pct = $urandom_range(65, 40);
			for (i = 0; i < 135; i++) begin
				if (ph == 1 && i == 20)
					hold_req <= 1'b1;
				offer_item(($urandom_range(99) < arr_pct) ? ACT_ARRIVE : ACT_TICK,
					$urandom_range(1) ? CLS_VIDEO : CLS_DATA);
			end
			wait_quiet();
		end

		// empty the queue, queue a burst, then expire everything in one tick
		load_regs(1, 1, 3, 2);
		repeat (8) offer_item(ACT_TICK, CLS_DATA);
		repeat (20)
			offer_item(ACT_ARRIVE, $urandom_range(1) ? CLS_VIDEO : CLS_DATA);
		offer_item(ACT_TICK, CLS_VIDEO);
		offer_item(ACT_TICK, CLS_DATA);
		wait_quiet();

		// highest settings last, since the busy timer then stays loaded for a long time
		load_regs(24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 16'hFFFF);
		offer_item(ACT_ARRIVE, CLS_DATA);
		offer_item(ACT_ARRIVE, CLS_VIDEO);
		repeat (3) offer_item(ACT_TICK, CLS_DATA);
		wait_quiet();

		if (err_count == 0)
			$display("deadline_drop_packet_queue_tb: clean");
		else
			$display("deadline_drop_packet_queue_tb: errors");
		$finish;
	end

endmodule

FILE: deadline_drop_packet_queue.f
rtl/core/ddpq_pkg.sv
rtl/core/ddpq_if.sv
rtl/core/ddpq_ram.sv
rtl/core/deadline_drop_packet_queue.sv
rtl/core/ddpq_checker.sv
test/ddpq_outcome_checker.sv
test/deadline_drop_packet_queue_tb.sv
